[rtl/blsc_pkg.sv]
// Shared types, gains and tanh table for the balance controller.
package blsc_pkg;

  localparam int TANH_ENTRIES = 256;
  localparam int TIDX_W       = $clog2(TANH_ENTRIES);
  localparam int ACC_W        = 48;
  localparam int PROD_W       = 57;

  localparam logic [15:0] INV_RESET   = 16'd100;
  localparam logic [23:0] PITCH_RESET = 24'sd11141;
  localparam logic [2:0]  ADDR_INV    = 3'd0;

  localparam int FIVE_Q16 = 327680;
  localparam int RECIP10  = 13421773;
  localparam int G_FF  = 39649;
  localparam int G_SP  = 149769;
  localparam int G_SR  = 50305;
  localparam int G_SY  = 62757;
  localparam int G_SYR = 52527;
  localparam int G_HX  = 146545;
  localparam int G_HXR = 245360;
  localparam int G_HP  = 755787;
  localparam int G_HPR = 284256;
  localparam int G_HY  = 46341;
  localparam int G_HYR = 89326;

  localparam longint unsigned TANH_H = (64'd8 << 30) / TANH_ENTRIES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    ST_DIV,
    ST_XR,
    ST_PR,
    ST_YR,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_G4,
    ST_G5,
    ST_G6,
    ST_TIDX
  } step_t;

  typedef struct packed {
    logic  in_ready;
    logic  take_pose;
    logic  take_cmd;
    logic  issue;
    step_t step;
    logic  load_out;
    logic  busy;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  typedef logic [19:0] tanh_tab_t [TANH_ENTRIES];

  // elaboration-time restoring divide for the table build
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh();
    longint unsigned h;
    longint unsigned term;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint r;
    tanh_tab_t t;
    h = TANH_H;
    term = 64'd1 << 30;
    r = 0;
    e = 64'd1 << 30;
    for (int k = 0; k < 12; k++) begin
      r = ((k & 1) == 1) ? r - longint'(term) : r + longint'(term);
      term = udiv(term * h, 64'(k + 1) << 30);
    end
    for (int i = 0; i < TANH_ENTRIES; i++) begin
      num = (64'd1 << 30) - e;
      den = (64'd1 << 30) + e;
      t[i] = 20'(udiv(64'(FIVE_Q16) * num + (den >> 1), den));
      e = (e * longint'(r) + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(8388607)) return 24'sh7fffff;
    if (v < -PROD_W'(8388608)) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

[rtl/blsc_if.sv]
// Input and result channel interfaces.
interface blsc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [23:0] position_x;
  logic signed [23:0] pitch_angle;
  logic signed [23:0] yaw_angle;
  logic signed [23:0] speed_command;
  logic signed [23:0] turn_command;
  modport source (output valid, operation, position_x, pitch_angle, yaw_angle,
                  speed_command, turn_command, input ready);
  modport sink (input valid, operation, position_x, pitch_angle, yaw_angle,
                speed_command, turn_command, output ready);
endinterface

interface blsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] torque_left;
  logic signed [23:0] torque_right;
  modport source (output valid, torque_left, torque_right, input ready);
  modport sink (input valid, torque_left, torque_right, output ready);
endinterface

[rtl/balance_lqr_sliding_controller_unit.sv]
// Top level: register port, sequencer and datapath of the balance controller.
// A pose beat runs in order: eleven issues on the one shared multiplier, a drain
// state, then a load state that waits until the previous result is accepted.
// Command beats are taken in idle and give no result; no beat is taken while busy.
// Synchronous active-low reset sets period 100, pitch 11141, the other kept state zero; result registers are not reset.
module balance_lqr_sliding_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  blsc_in_if.sink     in_beat,
  blsc_out_if.source  out_beat,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  blsc_pkg::cmd_t  cmd;
  blsc_pkg::stat_t stat;
  logic [15:0]     inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= blsc_pkg::INV_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == blsc_pkg::ADDR_INV) begin
      inv_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == blsc_pkg::ADDR_INV) ? {16'd0, inv_r} : 32'd0;

  blsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_beat.valid),
    .in_op    (in_beat.operation),
    .stat     (stat),
    .cmd      (cmd)
  );

  blsc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .position_x    (in_beat.position_x),
    .pitch_angle   (in_beat.pitch_angle),
    .yaw_angle     (in_beat.yaw_angle),
    .speed_command (in_beat.speed_command),
    .turn_command  (in_beat.turn_command),
    .inv_period    (inv_r),
    .out_ready     (out_beat.ready),
    .out_valid     (out_beat.valid),
    .torque_left   (out_beat.torque_left),
    .torque_right  (out_beat.torque_right)
  );

  assign in_beat.ready = cmd.in_ready;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.busy |-> !in_beat.ready) else $error("input taken while busy");

  a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat.valid && in_beat.ready && in_beat.operation) |=> !$rose(out_beat.valid))
    else $error("command beat produced a result");

  a_load_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (cmd.busy && !cmd.issue && !stat.out_busy))
    else $error("result loaded out of sequence");

endmodule

[rtl/blsc_ctrl.sv]
// Sequencer for beat acceptance, the shared multiply steps of one pose beat and the result load.
module blsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  input  blsc_pkg::stat_t stat,
  output blsc_pkg::cmd_t  cmd
);

  blsc_pkg::state_t state_r, state_nxt;
  blsc_pkg::step_t  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blsc_pkg::S_IDLE;
      step_r  <= blsc_pkg::ST_DIV;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      blsc_pkg::S_IDLE: begin
        step_nxt = blsc_pkg::ST_DIV;
        if (in_valid && !in_op) state_nxt = blsc_pkg::S_RUN;
      end
      blsc_pkg::S_RUN: begin
        if (step_r == blsc_pkg::ST_TIDX) state_nxt = blsc_pkg::S_DRAIN;
        else step_nxt = blsc_pkg::step_t'(step_r + 4'd1);
      end
      blsc_pkg::S_DRAIN: state_nxt = blsc_pkg::S_FIN;
      blsc_pkg::S_FIN: begin
        if (!stat.out_busy) state_nxt = blsc_pkg::S_IDLE;
      end
      default: state_nxt = blsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.step = step_r;
    unique case (state_r)
      blsc_pkg::S_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.take_pose = in_valid && !in_op;
        cmd.take_cmd  = in_valid && in_op;
      end
      blsc_pkg::S_RUN: begin
        cmd.issue = 1'b1;
        cmd.busy  = 1'b1;
      end
      blsc_pkg::S_DRAIN: cmd.busy = 1'b1;
      blsc_pkg::S_FIN: begin
        cmd.busy     = 1'b1;
        cmd.load_out = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/blsc_dp.sv]
// Datapath: state, shared multiplier, accumulators, tanh lookup, result register.
module blsc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  blsc_pkg::cmd_t     cmd,
  output blsc_pkg::stat_t    stat,
  input  logic signed [23:0] position_x,
  input  logic signed [23:0] pitch_angle,
  input  logic signed [23:0] yaw_angle,
  input  logic signed [23:0] speed_command,
  input  logic signed [23:0] turn_command,
  input  logic [15:0]        inv_period,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [23:0] torque_left,
  output logic signed [23:0] torque_right
);

  localparam int AW = blsc_pkg::ACC_W;
  localparam int PW = blsc_pkg::PROD_W;

  logic signed [23:0] last_x_r, last_p_r, last_y_r, speed_r, heading_r, hold_r;
  logic signed [24:0] dx_r, dp_r, dy_r, dxh_r, ye_r;
  logic signed [23:0] p_r, q10_r, xr_r, pr_r, yr_r, t_r;
  logic               hold_mode_r;
  logic signed [AW-1:0] accc_r, accd_r;
  logic signed [PW-1:0] prod_r;
  blsc_pkg::step_t    step_d_r;
  logic               issue_d_r;
  logic               out_valid_r;
  logic signed [23:0] tl_r, tr_r;

  logic signed [31:0] op_a;
  logic signed [24:0] op_b;
  logic signed [24:0] pe;
  logic signed [30:0] s_val;
  logic [29:0]        s_abs;
  logic [23:0]        sp_abs;
  logic [23:0]        q_mag;
  logic [PW-19:0]     tidx;
  logic [19:0]        tmag;
  logic signed [AW-1:0] prod_acc;
  logic               acc_to_c, acc_sub;
  logic signed [AW-1:0] lsum, rsum;
  logic signed [PW-1:0] lfull, rfull;

  assign pe     = 25'(p_r) - 25'(q10_r);
  assign s_val  = 31'(pe) * 31'sd50 + 31'(pr_r);
  assign s_abs  = s_val[30] ? 30'(-s_val) : s_val[29:0];
  assign sp_abs = speed_r[23] ? 24'(-speed_r) : speed_r;
  assign q_mag  = prod_r[50:27];
  assign tidx   = prod_r[PW-1:18];
  assign prod_acc = prod_r[AW-1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.step)
      blsc_pkg::ST_DIV: begin
        op_a = 32'({1'b0, sp_abs});
        op_b = 25'(blsc_pkg::RECIP10);
      end
      blsc_pkg::ST_XR: begin op_a = 32'(dx_r); op_b = 25'({1'b0, inv_period}); end
      blsc_pkg::ST_PR: begin op_a = 32'(dp_r); op_b = 25'({1'b0, inv_period}); end
      blsc_pkg::ST_YR: begin op_a = 32'(dy_r); op_b = 25'({1'b0, inv_period}); end
      blsc_pkg::ST_G1: begin
        op_a = hold_mode_r ? 32'(dxh_r) : 32'(speed_r);
        op_b = hold_mode_r ? 25'(blsc_pkg::G_HX) : 25'(blsc_pkg::G_FF);
      end
      blsc_pkg::ST_G2: begin
        op_a = hold_mode_r ? 32'(xr_r) : 32'(pe);
        op_b = hold_mode_r ? 25'(blsc_pkg::G_HXR) : 25'(blsc_pkg::G_SP);
      end
      blsc_pkg::ST_G3: begin
        op_a = hold_mode_r ? 32'(p_r) : 32'(pr_r);
        op_b = hold_mode_r ? 25'(blsc_pkg::G_HP) : 25'(blsc_pkg::G_SR);
      end
      blsc_pkg::ST_G4: begin
        op_a = hold_mode_r ? 32'(pr_r) : 32'sd0;
        op_b = 25'(blsc_pkg::G_HPR);
      end
      blsc_pkg::ST_G5: begin
        op_a = 32'(ye_r);
        op_b = hold_mode_r ? 25'(blsc_pkg::G_HY) : 25'(blsc_pkg::G_SY);
      end
      blsc_pkg::ST_G6: begin
        op_a = 32'(yr_r);
        op_b = hold_mode_r ? 25'(blsc_pkg::G_HYR) : 25'(blsc_pkg::G_SYR);
      end
      blsc_pkg::ST_TIDX: begin
        op_a = 32'({2'b00, s_abs});
        op_b = 25'(blsc_pkg::TANH_ENTRIES);
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    acc_to_c = 1'b0;
    acc_sub  = 1'b0;
    case (step_d_r)
      blsc_pkg::ST_G1: begin acc_to_c = 1'b1; acc_sub = hold_mode_r; end
      blsc_pkg::ST_G2, blsc_pkg::ST_G3, blsc_pkg::ST_G4: begin
        acc_to_c = 1'b1;
        acc_sub  = 1'b1;
      end
      default: begin acc_to_c = 1'b0; acc_sub = 1'b0; end
    endcase
  end

  always_comb begin
    if (tidx >= (PW - 18)'(blsc_pkg::TANH_ENTRIES)) tmag = 20'(blsc_pkg::FIVE_Q16);
    else tmag = blsc_pkg::TANH_TAB[tidx[blsc_pkg::TIDX_W-1:0]];
  end

  assign lsum  = (accc_r - accd_r + AW'(32768)) >>> 16;
  assign rsum  = (accc_r + accd_r + AW'(32768)) >>> 16;
  assign lfull = PW'(lsum) - PW'(t_r);
  assign rfull = PW'(rsum) - PW'(t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_p_r    <= blsc_pkg::PITCH_RESET;
      last_y_r    <= '0;
      speed_r     <= '0;
      heading_r   <= '0;
      hold_r      <= '0;
      issue_d_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      issue_d_r <= cmd.issue;
      if (cmd.take_cmd) begin
        if (speed_command != speed_r) hold_r <= last_x_r;
        speed_r   <= speed_command;
        heading_r <= turn_command;
      end
      if (cmd.take_pose) begin
        last_x_r <= position_x;
        last_p_r <= pitch_angle;
        last_y_r <= yaw_angle;
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    step_d_r <= cmd.step;
    prod_r   <= PW'(op_a) * PW'(op_b);
    if (cmd.take_pose) begin
      dx_r        <= 25'(position_x) - 25'(last_x_r);
      dp_r        <= 25'(pitch_angle) - 25'(last_p_r);
      dy_r        <= 25'(yaw_angle) - 25'(last_y_r);
      dxh_r       <= 25'(position_x) - 25'(hold_r);
      ye_r        <= 25'(yaw_angle) - 25'(heading_r);
      p_r         <= pitch_angle;
      hold_mode_r <= (speed_r == 24'sd0);
      accc_r      <= '0;
      accd_r      <= '0;
    end
    if (issue_d_r) begin
      case (step_d_r)
        blsc_pkg::ST_DIV: q10_r <= speed_r[23] ? 24'(-q_mag) : q_mag;
        blsc_pkg::ST_XR:  xr_r <= blsc_pkg::sat24(prod_r);
        blsc_pkg::ST_PR:  pr_r <= blsc_pkg::sat24(prod_r);
        blsc_pkg::ST_YR:  yr_r <= blsc_pkg::sat24(prod_r);
        blsc_pkg::ST_TIDX: begin
          if (hold_mode_r) t_r <= '0;
          else t_r <= s_val[30] ? -24'(tmag) : 24'(tmag);
        end
        default: begin
          if (acc_to_c) accc_r <= acc_sub ? accc_r - prod_acc : accc_r + prod_acc;
          else accd_r <= accd_r + prod_acc;
        end
      endcase
    end
    if (cmd.load_out) begin
      tl_r <= blsc_pkg::sat24(lfull);
      tr_r <= blsc_pkg::sat24(rfull);
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign torque_left   = tl_r;
  assign torque_right  = tr_r;

endmodule
